// File: rtl/base64_stream_codec_unit_macros.svh
// Assertion macros shared by the codec queue and back end.
// Each takes a label, a clock, a reset, an antecedent and a consequent.
`ifndef BASE64_STREAM_CODEC_UNIT_MACROS_SVH
`define BASE64_STREAM_CODEC_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define B64C_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("b64c assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define B64C_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("b64c assertion failed");

`else

`define B64C_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define B64C_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: rtl/b64c_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b64c_pkg;

  // Mode register codes; bit 1 selects decoding.
  localparam logic [1:0] MODE_ENC_STD = 2'd0;
  localparam logic [1:0] MODE_ENC_URL = 2'd1;
  localparam logic [1:0] MODE_DEC     = 2'd2;

  // Characters with a special meaning.
  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_DASH  = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_UNDER = 8'h5F;  // '_'
  localparam logic [7:0] CHAR_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  // Decoded value that marks an invalid character.
  localparam logic [6:0] DEC_INVALID = 7'd64;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       status;
    logic       out_last;
  } out_item_t;

  // One group of up to four results produced by a single input item.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [2:0]      cnt;
    logic            status;
    logic            last;
  } job_t;

  // Six-bit value to alphabet character.
  function automatic logic [7:0] enc_char(input logic [5:0] v, input logic url);
    logic [7:0] c;
    c = 8'd0;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = url ? CHAR_DASH : CHAR_PLUS;
    end else begin
      c = url ? CHAR_UNDER : CHAR_SLASH;
    end
    return c;
  endfunction

  // Alphabet character to six-bit value, or DEC_INVALID.
  function automatic logic [6:0] dec_value(input logic [7:0] c);
    logic [6:0] v;
    v = DEC_INVALID;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 7'(c - 8'h30 + 8'd52);
    end else if (c == CHAR_PLUS || c == CHAR_COMMA) begin
      v = 7'd62;
    end else if (c == CHAR_SLASH) begin
      v = 7'd63;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/b64c_front.sv
`timescale 1ns / 1ps
`default_nettype none

module b64c_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire b64c_pkg::in_item_t in_data,
  input  wire logic              q_full,
  output logic                   q_push,
  output b64c_pkg::job_t         q_data
);
  import b64c_pkg::*;

  logic [1:0]  mode;
  logic [7:0]  held_bytes [2];
  logic [1:0]  held_count, held_count_next;
  logic [5:0]  bit_store, bit_store_next;
  logic [2:0]  bit_count, bit_count_next;
  logic        halted, halted_next;
  logic        hold_we;
  logic        accept;

  logic        url;
  logic [1:0]  n;
  logic [23:0] word;
  logic        enc_emit;
  logic [7:0]  c;
  logic        ws;
  logic [6:0]  v;
  logic [11:0] acc;
  logic [3:0]  cnt;
  logic [2:0]  rem;
  logic [11:0] shifted;
  logic [11:0] keep_mask;
  job_t        job;

  assign accept   = in_valid && in_ready;
  assign in_ready = !q_full;
  assign url      = (mode == MODE_ENC_URL);
  assign c        = in_data.in_byte;

  // Mode register; the user must write it only while the block is idle, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ENC_STD;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  // Encoder operands.
  always_comb begin
    n        = (held_count > 2'd2) ? 2'd2 : held_count;
    enc_emit = in_data.in_last || (n == 2'd2);
    case (n)
      2'd0:    word = {c, 16'd0};
      2'd1:    word = {held_bytes[0], c, 8'd0};
      default: word = {held_bytes[0], held_bytes[1], c};
    endcase
  end

  // Decoder operands.
  always_comb begin
    ws        = (c >= CHAR_TAB && c <= CHAR_CR) || (c == CHAR_SPACE);
    v         = dec_value(c);
    acc       = {bit_store, v[5:0]};
    cnt       = {1'b0, bit_count} + 4'd6;
    rem       = cnt[2:0];
    shifted   = acc >> rem;
    keep_mask = (12'd1 << rem) - 12'd1;
  end

  // Classify the item, build its result group and the next state.
  always_comb begin
    job             = '0;
    held_count_next = held_count;
    bit_store_next  = bit_store;
    bit_count_next  = bit_count;
    halted_next     = halted;
    hold_we         = 1'b0;
    if (mode[1]) begin
      if (!halted && !ws) begin
        if (c == CHAR_PAD) begin
          halted_next = 1'b1;
        end else if (v[6]) begin
          job.cnt     = 3'd1;
          job.status  = 1'b1;
          job.last    = 1'b1;
          halted_next = 1'b1;
        end else begin
          if (cnt[3]) begin
            job.cnt      = 3'd1;
            job.chars[0] = shifted[7:0];
            job.last     = in_data.in_last;
          end
          bit_store_next = 6'(acc & keep_mask);
          bit_count_next = rem;
        end
      end
    end else begin
      if (!enc_emit) begin
        hold_we         = 1'b1;
        held_count_next = n + 2'd1;
      end else begin
        job.chars[0]    = enc_char(word[23:18], url);
        job.chars[1]    = enc_char(word[17:12], url);
        job.chars[2]    = (n >= 2'd1) ? enc_char(word[11:6], url) : CHAR_PAD;
        job.chars[3]    = (n == 2'd2) ? enc_char(word[5:0], url) : CHAR_PAD;
        job.cnt         = url ? ({1'b0, n} + 3'd2) : 3'd4;
        job.last        = in_data.in_last;
        held_count_next = 2'd0;
      end
    end
    if (in_data.in_last) begin
      held_count_next = 2'd0;
      bit_store_next  = 6'd0;
      bit_count_next  = 3'd0;
      halted_next     = 1'b0;
    end
  end

  assign q_push = accept && (job.cnt != 3'd0);
  assign q_data = job;

  // Stream state.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
      bit_store  <= 6'd0;
      bit_count  <= 3'd0;
      halted     <= 1'b0;
    end else if (accept) begin
      held_count <= held_count_next;
      bit_store  <= bit_store_next;
      bit_count  <= bit_count_next;
      halted     <= halted_next;
    end
  end

  // Gathered encoder bytes; held_count guards every read.
  always_ff @(posedge clk) begin
    if (accept && hold_we) begin
      held_bytes[n[0]] <= c;
    end
  end

endmodule

`default_nettype wire

// File: rtl/b64c_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module b64c_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire b64c_pkg::job_t  push_data,
  output logic                 full,
  input  wire logic            pop,
  output b64c_pkg::job_t       pop_data,
  output logic                 empty
);
  import b64c_pkg::*;
  `include "base64_stream_codec_unit_macros.svh"

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  `B64C_ASSERT_SAME(a_no_push_full, clk, rst, push, !full)
  `B64C_ASSERT_SAME(a_no_pop_empty, clk, rst, pop, !empty)
  `B64C_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 2'd1)

endmodule

`default_nettype wire

// File: rtl/b64c_back.sv
`timescale 1ns / 1ps
`default_nettype none

module b64c_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_empty,
  input  wire b64c_pkg::job_t   q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output b64c_pkg::out_item_t   out_data
);
  import b64c_pkg::*;
  `include "base64_stream_codec_unit_macros.svh"

  job_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       adv;
  logic       final_char;
  logic       take;

  assign adv        = !out_valid || out_ready;
  assign final_char = ({1'b0, idx} + 3'd1) == cur.cnt;
  assign take       = cur_valid && adv;
  assign q_pop      = !q_empty && (!cur_valid || (take && final_char));

  // Current group and its character index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (take) begin
      if (final_char) begin
        cur_valid <= 1'b0;
      end
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  // Output register: one result per transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.out_char <= cur.chars[idx];
      out_data.status   <= cur.status;
      out_data.out_last <= cur.last && final_char;
    end
  end

  `B64C_ASSERT_SAME(a_err_is_last, clk, rst, out_valid && out_data.status, out_data.out_last)
  `B64C_ASSERT_SAME(a_idx_in_group, clk, rst, cur_valid, {1'b0, idx} < cur.cnt)

endmodule

`default_nettype wire

// File: rtl/base64_stream_codec_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming base64 codec. The mode register picks standard encoding with '='
// padding, URL-safe encoding without padding, or decoding (mode 2 or 3). An
// input item is taken whenever the two-entry group queue has room; it is
// classified and the whole group of results it causes (up to four) is
// queued at once. Results leave through a registered output one per cycle
// unless out_ready stalls it, so the single output port sets the pace:
// encoding sends four characters per three bytes, decoding one character
// per cycle. Any item marked last ends the stream and resets codec state.
module base64_stream_codec_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire b64c_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output b64c_pkg::out_item_t      out_data
);
  import b64c_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  job_t q_wdata;
  job_t q_rdata;

  // Front: accept and classify input items.
  b64c_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  // Queue of result groups between front and back.
  b64c_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // Back: deliver results one transfer at a time.
  b64c_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
